FILE: rtl/tpas_pkg.sv
// shared types, constants and field layout for the trapezoid profile setpoint block
package tpas_pkg;

    // position fraction bits and adc resolution
    localparam int POS_FRAC_BITS = 24;
    localparam int ADC_BITS      = 12;

    // field widths
    localparam int POS_W    = POS_FRAC_BITS + 1;
    localparam int VEL_W    = 22;
    localparam int DRV_W    = 16;
    localparam int JOG_W    = 16;
    localparam int ACC_W    = 16;
    localparam int MAXV_W   = 21;
    localparam int REQ_W    = 2;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 21;

    // full travel and adc full scale
    localparam logic [POS_W-1:0]    ONE_POS = POS_W'(1) << POS_FRAC_BITS;
    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    // request kinds
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADJ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ACCEL = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_MAXV  = 2'd3;

    // configuration reset values
    localparam logic [ADC_BITS-1:0] LOWER_RST = '0;
    localparam logic [ADC_BITS-1:0] UPPER_RST = ADC_MAX;
    localparam logic [ACC_W-1:0]    ACCEL_RST = 16'd256;
    localparam logic [MAXV_W-1:0]   MAXV_RST  = 21'd16384;

    // input beat layout, lowest field first
    localparam int IN_VOLTS_LSB = 0;
    localparam int IN_DRV_LSB   = IN_VOLTS_LSB + ADC_BITS;
    localparam int IN_TGT_LSB   = IN_DRV_LSB + DRV_W;
    localparam int IN_JOG_LSB   = IN_TGT_LSB + POS_W;
    localparam int IN_BITS      = IN_JOG_LSB + JOG_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output beat layout, lowest field first
    localparam int OUT_BITS    = ADC_BITS + DRV_W + POS_W + VEL_W + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [ADC_BITS-1:0] lower;
        logic [ADC_BITS-1:0] upper;
        logic [ACC_W-1:0]    accel;
        logic [MAXV_W-1:0]   maxv;
    } t_cfg;

    typedef struct packed {
        logic [REQ_W-1:0]        req;
        logic [ADC_BITS-1:0]     volts;
        logic signed [DRV_W-1:0] drive;
        logic [POS_W-1:0]        tgt;
        logic signed [JOG_W-1:0] jog;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]        target;
        logic [POS_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
        logic signed [DRV_W-1:0] drive;
    } t_state;

    typedef struct packed {
        logic near;
        logic decel;
    } t_flags;

endpackage

FILE: rtl/tpas_update.sv
// per-item state update: target set and jog, near-target snap, trapezoid step, drive guard
module tpas_update (
    input  tpas_pkg::t_cfg   i_cfg,
    input  tpas_pkg::t_state i_state,
    input  tpas_pkg::t_item  i_item,
    output tpas_pkg::t_state o_state,
    output tpas_pkg::t_flags o_flags
);

    localparam int RW = tpas_pkg::ADC_BITS + 1;
    localparam int NW = tpas_pkg::POS_W + tpas_pkg::ADC_BITS + 6;
    localparam int PW = tpas_pkg::POS_W + tpas_pkg::ADC_BITS;
    localparam int SW = tpas_pkg::POS_W + 2;
    localparam int VW = tpas_pkg::VEL_W + 1;
    localparam int AW = tpas_pkg::ACC_W + 1;
    localparam int MW = tpas_pkg::ACC_W + 8;
    localparam int JW = MW + tpas_pkg::JOG_W + 1;
    localparam int DW = tpas_pkg::ACC_W + tpas_pkg::POS_W;
    localparam int QW = 2 * tpas_pkg::VEL_W;

    logic signed [RW-1:0]   rng;
    logic                   rng_pos;
    logic signed [RW-1:0]   vdiff;
    logic signed [NW-1:0]   lhs_base;
    logic signed [NW-1:0]   lhs;
    logic [PW-1:0]          tr_prod;
    logic signed [NW-1:0]   tr_s;
    logic signed [NW-1:0]   rhs_lo;
    logic signed [NW-1:0]   rhs_hi;
    logic                   near;

    logic signed [tpas_pkg::POS_W:0]  gap;
    logic [tpas_pkg::POS_W-1:0]       adist;
    logic [tpas_pkg::VEL_W-1:0]       av;
    logic [DW-1:0]                    ad_prod;
    logic [QW-1:0]                    av_sq;
    logic                             decel;
    logic                             up;
    logic signed [VW-1:0]             vel_x;
    logic signed [VW-1:0]             maxv_s;
    logic signed [AW-1:0]             accel_s;
    logic signed [AW-1:0]             acc;
    logic signed [VW-1:0]             vel_sum;
    logic signed [VW-1:0]             vel_clip;
    logic signed [tpas_pkg::VEL_W-1:0] vel_new;
    logic signed [SW-1:0]             pos_sum;
    logic [tpas_pkg::POS_W-1:0]       pos_new;

    logic [MW-1:0]                    acc200;
    logic signed [JW-1:0]             jog_prod;
    logic signed [SW-1:0]             jog_d;
    logic signed [SW-1:0]             adj_sum;
    logic [tpas_pkg::POS_W-1:0]       adj_tgt;
    logic [tpas_pkg::POS_W-1:0]       set_tgt;

    logic                             drv_pos;
    logic                             drv_neg;
    logic signed [tpas_pkg::DRV_W-1:0] drv_guard;

    // near-target band test by cross multiplication
    assign rng      = $signed({1'b0, i_cfg.upper}) - $signed({1'b0, i_cfg.lower});
    assign rng_pos  = !rng[RW-1] && (rng != '0);
    assign vdiff    = $signed({1'b0, i_item.volts}) - $signed({1'b0, i_cfg.lower});
    assign lhs_base = NW'(vdiff);
    assign lhs      = (lhs_base <<< (tpas_pkg::POS_FRAC_BITS + 4))
                    + (lhs_base <<< (tpas_pkg::POS_FRAC_BITS + 2));
    assign tr_prod  = PW'(i_state.target) * PW'(rng[RW-2:0]);
    assign tr_s     = $signed(NW'(tr_prod));
    assign rhs_lo   = (tr_s <<< 4) + (tr_s <<< 1) + tr_s;
    assign rhs_hi   = (tr_s <<< 4) + (tr_s <<< 2) + tr_s;
    assign near     = rng_pos && (lhs > rhs_lo) && (lhs < rhs_hi);

    // braking distance check: 2*a*|d| against v squared
    assign gap     = $signed({1'b0, i_state.target}) - $signed({1'b0, i_state.pos});
    assign adist   = gap[tpas_pkg::POS_W] ? tpas_pkg::POS_W'(-gap)
                                          : gap[tpas_pkg::POS_W-1:0];
    assign av      = i_state.vel[tpas_pkg::VEL_W-1] ? tpas_pkg::VEL_W'(-i_state.vel)
                                                    : tpas_pkg::VEL_W'(i_state.vel);
    assign ad_prod = DW'(i_cfg.accel) * DW'(adist);
    assign av_sq   = QW'(av) * QW'(av);
    assign decel   = QW'({ad_prod, 1'b0}) < av_sq;
    assign up      = i_state.pos < i_state.target;

    // velocity step with speed limit
    assign vel_x   = VW'($signed(i_state.vel));
    assign maxv_s  = $signed(VW'(i_cfg.maxv));
    assign accel_s = $signed({1'b0, i_cfg.accel});

    always_comb begin
        acc = '0;
        if (up && (vel_x < maxv_s)) begin
            acc = accel_s;
        end
        if (!up && (vel_x > -maxv_s)) begin
            acc = -accel_s;
        end
        if (decel) begin
            acc = up ? -accel_s : accel_s;
        end
    end

    assign vel_sum = vel_x + VW'(acc);

    always_comb begin
        if (vel_sum > maxv_s) begin
            vel_clip = maxv_s;
        end else if (vel_sum < -maxv_s) begin
            vel_clip = -maxv_s;
        end else begin
            vel_clip = vel_sum;
        end
    end

    assign vel_new = tpas_pkg::VEL_W'(vel_clip);

    // position step clamped to travel
    assign pos_sum = $signed({2'b00, i_state.pos}) + SW'(vel_new);

    always_comb begin
        if (pos_sum[SW-1]) begin
            pos_new = '0;
        end else if (pos_sum > $signed(SW'(tpas_pkg::ONE_POS))) begin
            pos_new = tpas_pkg::ONE_POS;
        end else begin
            pos_new = pos_sum[tpas_pkg::POS_W-1:0];
        end
    end

    // jog: floor(200*accel*jog / 2^15), then clamp
    assign acc200   = (MW'(i_cfg.accel) << 7) + (MW'(i_cfg.accel) << 6)
                    + (MW'(i_cfg.accel) << 3);
    assign jog_prod = JW'($signed({1'b0, acc200})) * JW'(i_item.jog);
    assign jog_d    = SW'(jog_prod >>> (tpas_pkg::JOG_W - 1));
    assign adj_sum  = $signed({2'b00, i_state.target}) + jog_d;

    always_comb begin
        if (adj_sum[SW-1]) begin
            adj_tgt = '0;
        end else if (adj_sum > $signed(SW'(tpas_pkg::ONE_POS))) begin
            adj_tgt = tpas_pkg::ONE_POS;
        end else begin
            adj_tgt = adj_sum[tpas_pkg::POS_W-1:0];
        end
    end

    assign set_tgt = (i_item.tgt > tpas_pkg::ONE_POS) ? tpas_pkg::ONE_POS : i_item.tgt;

    // drive guard against pushing past a limit
    assign drv_pos   = !i_item.drive[tpas_pkg::DRV_W-1] && (i_item.drive != '0);
    assign drv_neg   = i_item.drive[tpas_pkg::DRV_W-1];
    assign drv_guard = ((drv_pos && (i_item.volts > i_cfg.upper))
                     || (drv_neg && (i_item.volts < i_cfg.lower))) ? '0 : i_item.drive;

    // select by request kind
    always_comb begin
        o_state       = i_state;
        o_flags.near  = 1'b0;
        o_flags.decel = 1'b0;
        case (i_item.req)
            tpas_pkg::REQ_TICK: begin
                o_flags.near  = near;
                o_state.drive = drv_guard;
                if (near) begin
                    o_state.vel = '0;
                    o_state.pos = i_state.target;
                end else begin
                    o_flags.decel = decel;
                    o_state.vel   = vel_new;
                    o_state.pos   = pos_new;
                end
            end
            tpas_pkg::REQ_SET: begin
                o_state.target = set_tgt;
            end
            tpas_pkg::REQ_ADJ: begin
                o_state.target = adj_tgt;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

FILE: rtl/tpas_setpoint.sv
// maps profile position to potentiometer adc units with round-half-up and clamp
module tpas_setpoint (
    input  tpas_pkg::t_cfg                   i_cfg,
    input  logic [tpas_pkg::POS_W-1:0]       i_pos,
    output logic [tpas_pkg::ADC_BITS-1:0]    o_volts
);

    localparam int RW = tpas_pkg::ADC_BITS + 1;
    localparam int SW = tpas_pkg::POS_W + tpas_pkg::ADC_BITS + 2;
    localparam int QW = tpas_pkg::ADC_BITS + 2;

    logic signed [RW-1:0] rng;
    logic signed [SW-1:0] prod;
    logic signed [SW-1:0] rnd;
    logic signed [SW-1:0] quo;
    logic signed [QW-1:0] val;

    // lower + floor((pos*range + half) / one)
    assign rng  = $signed({1'b0, i_cfg.upper}) - $signed({1'b0, i_cfg.lower});
    assign prod = SW'($signed({1'b0, i_pos})) * SW'(rng);
    assign rnd  = prod + $signed(SW'(1) << (tpas_pkg::POS_FRAC_BITS - 1));
    assign quo  = rnd >>> tpas_pkg::POS_FRAC_BITS;
    assign val  = QW'(quo) + $signed({2'b00, i_cfg.lower});

    // clamp to adc range
    always_comb begin
        if (val[QW-1]) begin
            o_volts = '0;
        end else if (val > $signed(QW'(tpas_pkg::ADC_MAX))) begin
            o_volts = tpas_pkg::ADC_MAX;
        end else begin
            o_volts = val[tpas_pkg::ADC_BITS-1:0];
        end
    end

endmodule

FILE: rtl/trapezoid_profile_arm_setpoint_top.sv
// top level: config registers, input register, profile state, middle register, result register
// Trapezoidal setpoint generator for a potentiometer-sensed arm. Each input beat
// is a tick, a target set or a target jog, and each gives exactly one result
// beat. One beat is taken per clock unless the result stream stalls; a result
// is presented after the state update from the input register into the middle
// register, then adc mapping into the output register. The one-beat-per-clock
// rate is set by the profile state loop, combinational between the state
// registers: the near-target and braking products feed them directly so the
// next beat sees the updated target, position and velocity.
// Configuration registers take a write on any clock with i_cfg_we high and
// should only be written while no beat is in flight.
module trapezoid_profile_arm_setpoint_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [tpas_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [tpas_pkg::CFG_DW-1:0]          i_cfg_wdata,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // measured_volts, drive_request, target_fraction, jog_increment, zero pad
    input  logic [tpas_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // req_type
    input  logic [tpas_pkg::REQ_W-1:0]           i_s_tuser,
    // result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // setpoint_volts, motor_drive, profile_position, profile_velocity,
    // at_target, decelerating, zero pad
    output logic [tpas_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    tpas_pkg::t_cfg   r_cfg;
    logic             r_in_v;
    tpas_pkg::t_item  r_in;
    tpas_pkg::t_state r_state;
    tpas_pkg::t_state n_state;
    tpas_pkg::t_flags n_flags;
    logic             r_mid_v;
    tpas_pkg::t_state r_mid_st;
    tpas_pkg::t_flags r_mid_fl;
    logic             r_mid_tick;
    logic             r_out_v;
    logic [tpas_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [tpas_pkg::OUT_TDATA_W-1:0] n_out_data;
    logic [tpas_pkg::ADC_BITS-1:0]    sp_volts;

    logic adv_out;
    logic adv_mid;
    logic adv_in;

    // pipeline advance, each stage moves when the next one is free
    assign adv_out    = !r_out_v || i_m_tready;
    assign adv_mid    = !r_mid_v || adv_out;
    assign adv_in     = !r_in_v || adv_mid;
    assign o_s_tready = adv_in;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower <= tpas_pkg::LOWER_RST;
            r_cfg.upper <= tpas_pkg::UPPER_RST;
            r_cfg.accel <= tpas_pkg::ACCEL_RST;
            r_cfg.maxv  <= tpas_pkg::MAXV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tpas_pkg::CFG_LOWER: r_cfg.lower <= i_cfg_wdata[tpas_pkg::ADC_BITS-1:0];
                tpas_pkg::CFG_UPPER: r_cfg.upper <= i_cfg_wdata[tpas_pkg::ADC_BITS-1:0];
                tpas_pkg::CFG_ACCEL: r_cfg.accel <= i_cfg_wdata[tpas_pkg::ACC_W-1:0];
                tpas_pkg::CFG_MAXV:  r_cfg.maxv  <= i_cfg_wdata[tpas_pkg::MAXV_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (adv_in) begin
            r_in_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_s_tvalid) begin
            r_in.req   <= i_s_tuser;
            r_in.volts <= i_s_tdata[tpas_pkg::IN_VOLTS_LSB +: tpas_pkg::ADC_BITS];
            r_in.drive <= i_s_tdata[tpas_pkg::IN_DRV_LSB +: tpas_pkg::DRV_W];
            r_in.tgt   <= i_s_tdata[tpas_pkg::IN_TGT_LSB +: tpas_pkg::POS_W];
            r_in.jog   <= i_s_tdata[tpas_pkg::IN_JOG_LSB +: tpas_pkg::JOG_W];
        end
    end

    // state update for the beat in the input register
    tpas_update u_update (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_flags (n_flags)
    );

    // profile state, committed once per beat as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv_mid && r_in_v) begin
            r_state <= n_state;
        end
    end

    // middle stage carries the post-beat state snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_v <= 1'b0;
        end else if (adv_mid) begin
            r_mid_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_mid && r_in_v) begin
            r_mid_st   <= n_state;
            r_mid_fl   <= n_flags;
            r_mid_tick <= (r_in.req == tpas_pkg::REQ_TICK);
        end
    end

    // adc mapping of the snapshot position
    tpas_setpoint u_setpoint (
        .i_cfg   (r_cfg),
        .i_pos   (r_mid_st.pos),
        .o_volts (sp_volts)
    );

    assign n_out_data = tpas_pkg::OUT_TDATA_W'({r_mid_fl.decel, r_mid_fl.near,
                                                r_mid_st.vel, r_mid_st.pos,
                                                r_mid_st.drive, sp_volts});

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv_out) begin
            r_out_v <= r_mid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_mid_v) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= tpas_pkg::ONE_POS)
        else $error("profile position beyond full travel");

    a_tgt_in_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.target <= tpas_pkg::ONE_POS)
        else $error("desired target beyond full travel");

    a_snap_no_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_v |-> !(r_mid_fl.near && r_mid_fl.decel))
        else $error("snap and braking flagged on the same beat");

    a_flags_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_v && !r_mid_tick) |-> (!r_mid_fl.near && !r_mid_fl.decel))
        else $error("status flag raised on a non-tick beat");

    a_nontick_holds_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_mid && r_in_v && (r_in.req != tpas_pkg::REQ_TICK))
        |=> ($stable(r_state.pos) && $stable(r_state.vel) && $stable(r_state.drive)))
        else $error("non-tick beat changed profile motion");
`endif

endmodule

FILE: sim/tpas_profile_checker.sv
`timescale 1ns / 1ps
// checker: watches config writes and both streams, predicts each result beat and compares it
module tpas_profile_checker
    import tpas_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_addr,
    input  logic [CFG_DW-1:0]       i_cfg_wdata,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    // measured_volts, drive_request, target_fraction, jog_increment, zero pad
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,
    // req_type
    input  logic [REQ_W-1:0]        i_s_tuser,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    // setpoint_volts, motor_drive, profile_position, profile_velocity,
    // at_target, decelerating, zero pad
    input  logic [OUT_TDATA_W-1:0]  i_m_tdata,
    output int                      o_pending,
    output int                      o_fail_cnt
);

    localparam longint FULL_TRAVEL = longint'(1) << POS_FRAC_BITS;
    localparam longint ADC_TOP     = (longint'(1) << ADC_BITS) - 1;

    typedef struct {
        logic [ADC_BITS-1:0]     setpoint;
        logic signed [DRV_W-1:0] drive;
        logic [POS_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
        logic                    near;
        logic                    decel;
    } t_result;

    t_cfg    cfg;
    t_state  st;
    t_result setpoint_q[$];
    int      mismatch_cnt = 0;

    assign o_fail_cnt = mismatch_cnt;

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // one item through the profile: target update, tick motion, drive guard, adc mapping
    function automatic t_result advance_profile(input t_item it);
        longint  lower, upper, span, accel, maxv, volts;
        longint  tgt, pos, vel, drv, lhs, gap, adist, av, acc, sp;
        logic    near, decel, up;
        t_result r;
        lower = longint'(cfg.lower);
        upper = longint'(cfg.upper);
        span  = upper - lower;
        accel = longint'(cfg.accel);
        maxv  = longint'(cfg.maxv);
        volts = longint'(it.volts);
        tgt   = longint'(st.target);
        pos   = longint'(st.pos);
        vel   = longint'($signed(st.vel));
        drv   = longint'($signed(st.drive));
        near  = 1'b0;
        decel = 1'b0;
        case (it.req)
            REQ_SET: begin
                tgt = clip(longint'(it.tgt), 0, FULL_TRAVEL);
            end
            REQ_ADJ: begin
                tgt = clip(tgt + ((200 * accel * longint'($signed(it.jog))) >>> 15),
                           0, FULL_TRAVEL);
            end
            REQ_TICK: begin
                // five percent band around the target, by cross multiplication
                if (span > 0) begin
                    lhs  = 20 * (volts - lower) * FULL_TRAVEL;
                    near = (lhs > 19 * tgt * span) && (lhs < 21 * tgt * span);
                end
                if (near) begin
                    vel = 0;
                    pos = tgt;
                end else begin
                    // accelerate toward the target, brake inside the stopping distance
                    gap   = tgt - pos;
                    adist = (gap < 0) ? -gap : gap;
                    av    = (vel < 0) ? -vel : vel;
                    up    = pos < tgt;
                    acc   = 0;
                    decel = (2 * accel * adist) < (av * av);
                    if (up && vel < maxv)
                        acc = accel;
                    if (!up && vel > -maxv)
                        acc = -accel;
                    if (decel)
                        acc = up ? -accel : accel;
                    vel = clip(vel + acc, -maxv, maxv);
                    pos = clip(pos + vel, 0, FULL_TRAVEL);
                end
                // no drive that pushes past a limit
                drv = longint'($signed(it.drive));
                if (drv > 0 && volts > upper)
                    drv = 0;
                if (drv < 0 && volts < lower)
                    drv = 0;
            end
            default: ;
        endcase
        st.target = POS_W'(tgt);
        st.pos    = POS_W'(pos);
        st.vel    = VEL_W'(vel);
        st.drive  = DRV_W'(drv);
        // position to adc units, halves rounded up
        sp = lower + ((pos * span + (FULL_TRAVEL >>> 1)) >>> POS_FRAC_BITS);
        r.setpoint = ADC_BITS'(clip(sp, 0, ADC_TOP));
        r.drive    = st.drive;
        r.pos      = st.pos;
        r.vel      = st.vel;
        r.near     = near;
        r.decel    = decel;
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // watch config writes, result beats and input beats
    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg.lower = LOWER_RST;
            cfg.upper = UPPER_RST;
            cfg.accel = ACCEL_RST;
            cfg.maxv  = MAXV_RST;
            st        = '0;
            setpoint_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LOWER: cfg.lower = i_cfg_wdata[ADC_BITS-1:0];
                    CFG_UPPER: cfg.upper = i_cfg_wdata[ADC_BITS-1:0];
                    CFG_ACCEL: cfg.accel = i_cfg_wdata[ACC_W-1:0];
                    CFG_MAXV:  cfg.maxv  = i_cfg_wdata[MAXV_W-1:0];
                    default: ;
                endcase
            end
            // result beat against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got.setpoint = i_m_tdata[ADC_BITS-1:0];
                got.drive    = i_m_tdata[ADC_BITS +: DRV_W];
                got.pos      = i_m_tdata[ADC_BITS+DRV_W +: POS_W];
                got.vel      = i_m_tdata[ADC_BITS+DRV_W+POS_W +: VEL_W];
                got.near     = i_m_tdata[OUT_BITS-2];
                got.decel    = i_m_tdata[OUT_BITS-1];
                if (setpoint_q.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    mismatch_cnt++;
                end else begin
                    want = setpoint_q.pop_front();
                    compare_field("setpoint_volts", want.setpoint, got.setpoint);
                    compare_field("motor_drive", $signed(want.drive), $signed(got.drive));
                    compare_field("profile_position", want.pos, got.pos);
                    compare_field("profile_velocity", $signed(want.vel), $signed(got.vel));
                    compare_field("at_target", want.near, got.near);
                    compare_field("decelerating", want.decel, got.decel);
                end
            end
            // input beat into the predictor
            if (i_s_tvalid && i_s_tready) begin
                it.req   = i_s_tuser;
                it.volts = i_s_tdata[IN_VOLTS_LSB +: ADC_BITS];
                it.drive = i_s_tdata[IN_DRV_LSB +: DRV_W];
                it.tgt   = i_s_tdata[IN_TGT_LSB +: POS_W];
                it.jog   = i_s_tdata[IN_JOG_LSB +: JOG_W];
                setpoint_q.push_back(advance_profile(it));
            end
        end
        o_pending <= setpoint_q.size();
    end

endmodule

FILE: sim/tb_trapezoid_profile_arm_setpoint_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus phases, receiver stalls and the verdict
module tb_trapezoid_profile_arm_setpoint_top;
    import tpas_pkg::*;

    localparam int         RUN_LIMIT   = 200000;
    localparam int         PHASE_BEATS = 205;
    localparam logic [1:0] REQ_SPARE   = 2'd3;
    localparam longint     FULL_TRAVEL = longint'(1) << POS_FRAC_BITS;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_addr  = '0;
    logic [CFG_DW-1:0]      i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [REQ_W-1:0]       i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    int     exp_pending;
    int     fail_cnt;
    int     cycle_cnt      = 0;
    int     beats_sent     = 0;
    int     src_idle_pct   = 0;
    int     sink_stall_pct = 0;
    logic   hold_off       = 1'b0;

    // stimulus copy of the settings and of the target, for steering the measured position
    int     lo_cfg  = 0;
    int     hi_cfg  = 4095;
    int     acc_cfg = 256;
    longint aim     = 0;

    trapezoid_profile_arm_setpoint_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    tpas_profile_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_pending   (exp_pending),
        .o_fail_cnt  (fail_cnt)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("trapezoid_profile_arm_setpoint_top: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end

    // long hold-off while the sender keeps offering beats, so the block backs up
    initial begin
        wait (beats_sent >= 80);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (120) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic longint clip_travel(input longint x);
        return (x < 0) ? 0 : ((x > FULL_TRAVEL) ? FULL_TRAVEL : x);
    endfunction

    function automatic int rand_drive();
        if ($urandom_range(6) == 0)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(32768)) - 16384;
    endfunction

    function automatic int rand_jog();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // measured reading close to where the target maps in adc units
    function automatic int near_volts();
        longint v;
        v = longint'(lo_cfg) + ((aim * longint'(hi_cfg - lo_cfg)) >>> POS_FRAC_BITS)
            + longint'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return int'(v);
    endfunction

    // offer one beat, with a random idle gap before it, and wait for acceptance
    task automatic push_request(input logic [REQ_W-1:0] req, input int volts,
                                input int drive, input int tgt, input int jog);
        logic [IN_TDATA_W-1:0] beat;
        beat                               = '0;
        beat[IN_VOLTS_LSB +: ADC_BITS]     = ADC_BITS'(volts);
        beat[IN_DRV_LSB +: DRV_W]          = DRV_W'(drive);
        beat[IN_TGT_LSB +: POS_W]          = POS_W'(tgt);
        beat[IN_JOG_LSB +: JOG_W]          = JOG_W'(jog);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // stop sending and let every predicted result come out, plus pipeline slack
    task automatic settle_pipeline();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_config(input int lower, input int upper, input int accel,
                               input int maxv);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_LOWER;
        i_cfg_wdata <= CFG_DW'(lower);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_UPPER;
        i_cfg_wdata <= CFG_DW'(upper);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_ACCEL;
        i_cfg_wdata <= CFG_DW'(accel);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MAXV;
        i_cfg_wdata <= CFG_DW'(maxv);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lo_cfg  = lower;
        hi_cfg  = upper;
        acc_cfg = accel;
    endtask

    // random traffic: mostly set-and-move runs, some jogging, some noise
    task automatic profile_traffic(input int n);
        int                done;
        int                pick;
        int                len;
        int                tgt;
        int                jog;
        logic [REQ_W-1:0]  req;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                // set a target, then tick toward it; the arm arrives near the end
                if ($urandom_range(7) == 0)
                    tgt = $urandom_range(33554431);
                else
                    tgt = int'(clip_travel(aim + longint'($urandom_range(1 << 19))
                                           - (1 << 18)));
                push_request(REQ_SET, $urandom_range(4095), rand_drive(), tgt, rand_jog());
                aim = clip_travel(tgt);
                len = $urandom_range(50, 6);
                for (int k = 0; k < len; k++) begin
                    push_request(REQ_TICK,
                                 (k >= len - 2 || $urandom_range(9) == 0) ?
                                     near_volts() : $urandom_range(4095),
                                 rand_drive(), $urandom_range(33554431), rand_jog());
                end
                done += len + 1;
            end else if (pick < 80) begin
                // jog the target between ticks
                len = $urandom_range(12, 2);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(1) == 1) begin
                        jog = rand_jog();
                        push_request(REQ_ADJ, $urandom_range(4095), rand_drive(),
                                     $urandom_range(33554431), jog);
                        aim = clip_travel(aim + ((200 * longint'(acc_cfg) * longint'(jog))
                                                 >>> 15));
                    end else begin
                        push_request(REQ_TICK,
                                     $urandom_range(1) ? near_volts() : $urandom_range(4095),
                                     rand_drive(), $urandom_range(33554431), rand_jog());
                    end
                end
                done += len;
            end else begin
                // noise: any request code, any field value
                req = REQ_W'($urandom_range(3));
                tgt = $urandom_range(33554431);
                jog = rand_jog();
                push_request(req, $urandom_range(4095), rand_drive(), tgt, jog);
                if (req == REQ_SET)
                    aim = clip_travel(tgt);
                else if (req == REQ_ADJ)
                    aim = clip_travel(aim + ((200 * longint'(acc_cfg) * longint'(jog)) >>> 15));
                done++;
            end
        end
    endtask

    task automatic run_phase(input int lower, input int upper, input int accel, input int maxv,
                             input int src_pct, input int sink_pct);
        settle_pipeline();
        load_config(lower, upper, accel, maxv);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        profile_traffic(PHASE_BEATS);
    endtask

    // main sequence
    initial begin
        int lower;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero target with equal positions, clamps, snap, spare code
        push_request(REQ_TICK, 0, 16384, 0, 0);
        push_request(REQ_SET, 0, 0, 33554431, 0);
        push_request(REQ_TICK, 4095, 16384, 0, 0);
        push_request(REQ_ADJ, 0, 0, 0, 32767);
        push_request(REQ_ADJ, 4095, -16384, 0, -32768);
        push_request(REQ_ADJ, 0, 0, 0, -32768);
        push_request(REQ_TICK, 0, -16384, 0, 0);
        push_request(REQ_TICK, 0, -16384, 0, 0);
        push_request(REQ_SPARE, 4095, -1, 33554431, -1);
        push_request(REQ_SET, 0, 0, 0, 0);
        push_request(REQ_TICK, 2048, 16384, 0, 0);
        push_request(REQ_SET, 0, 0, 8388608, 0);
        for (int k = 0; k < 8; k++)
            push_request(REQ_TICK, 0, (k % 2 == 0) ? 16384 : -16384, 0, 0);
        push_request(REQ_TICK, 2048, 1, 0, 0);
        push_request(REQ_ADJ, 0, 0, 0, -1);
        push_request(REQ_ADJ, 0, 0, 0, 1);
        push_request(REQ_SET, 0, 0, 16777216, 0);
        push_request(REQ_TICK, 100, 0, 0, 0);
        aim = FULL_TRAVEL;

        // phases over settings and idling patterns, extremes included
        run_phase(0, 4095, 256, 16384, 0, 0);
        run_phase(100, 3900, 1, 1, 60, 0);
        run_phase(4095, 0, 65535, 1048576, 0, 60);
        run_phase(2000, 2000, 512, 0, 26, 26);
        run_phase(0, 4095, 65535, 1048576, 0, 0);
        run_phase(300, 3500, 1024, 65536, 60, 0);
        lower = $urandom_range(2000);
        run_phase(lower, $urandom_range(4095, lower + 1), $urandom_range(65535, 1),
                  $urandom_range(1048576), 0, 60);
        run_phase($urandom_range(4095), $urandom_range(4095), $urandom_range(65535, 1),
                  $urandom_range(1048576), 26, 26);

        settle_pipeline();
        if (fail_cnt == 0)
            $display("trapezoid_profile_arm_setpoint_top: match");
        else
            $display("trapezoid_profile_arm_setpoint_top: mismatch");
        $finish;
    end

endmodule
